### design/arq_sender_with_duplicate_filter_core_macros.svh
// ----------------------------------------------------------------------------
// ARQ sender assertion macros
// Shared shorthands for the concurrent checks of the ARQ sender core.
// ----------------------------------------------------------------------------
`ifndef ARQ_SENDER_WITH_DUPLICATE_FILTER_CORE_MACROS_SVH
`define ARQ_SENDER_WITH_DUPLICATE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ARQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ARQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/arq_sdf_pkg.sv
// ----------------------------------------------------------------------------
// ARQ sender package
// Types, codes and sizes shared by the ARQ sender core.
// ----------------------------------------------------------------------------
`default_nettype none

package arq_sdf_pkg;

  // Header size of a received frame, in bytes
  localparam int unsigned HEADER_BYTES = 8;
  localparam logic [7:0]  HDR_LEN      = 8'(HEADER_BYTES);

  // Queue sizes (powers of two, pointers wrap naturally)
  localparam int unsigned OPQ_DEPTH  = 2;
  localparam int unsigned OPQ_AW     = $clog2(OPQ_DEPTH);
  localparam int unsigned OPQ_CW     = OPQ_AW + 1;
  localparam int unsigned RESQ_DEPTH = 4;
  localparam int unsigned RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int unsigned RESQ_CW    = RESQ_AW + 1;

  // Configuration register indexes
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd0;
  localparam logic [1:0] REG_RETRY_BACKOFF = 2'd1;
  localparam logic [1:0] REG_SEND_TIMEOUT  = 2'd2;

  // Drop reasons
  localparam logic DROP_SHORT = 1'b0;
  localparam logic DROP_DUP   = 1'b1;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_TX_DONE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_RX_HDR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_TX_REQ     = 3'd0,
    KIND_OUTCOME    = 3'd1,
    KIND_RX_DELIVER = 3'd2,
    KIND_RX_DROP    = 3'd3,
    KIND_BUSY       = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OUT_OK      = 2'd0,
    OUT_TIMEOUT = 2'd1,
    OUT_RETRIES = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [7:0]  retry_limit;
    logic [15:0] retry_backoff_ms;
    logic [31:0] send_timeout_ms;
  } cfg_t;

  // Classified input item
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] nonce;
    logic [7:0]  packet_id;
    logic        status_ok;
    logic        too_short;
    logic [7:0]  payload_length;
  } op_t;

  // One result beat
  typedef struct packed {
    kind_e       kind;
    logic [31:0] out_nonce;
    logic [7:0]  out_packet_id;
    outcome_e    outcome;
    logic [7:0]  payload_length;
    logic        drop_reason;
    logic        last;
  } res_t;

  function automatic res_t make_res(kind_e k, logic [31:0] nonce, logic [7:0] pid,
                                    outcome_e oc, logic [7:0] plen, logic drop);
    res_t r;
    r.kind           = k;
    r.out_nonce      = nonce;
    r.out_packet_id  = pid;
    r.outcome        = oc;
    r.payload_length = plen;
    r.drop_reason    = drop;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### design/arq_sdf_if.sv
// ----------------------------------------------------------------------------
// ARQ sender channel interfaces
// Valid/ready channels for input items and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface arq_sdf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] nonce;
  logic [7:0]  packet_id;
  logic [7:0]  send_status;
  logic [7:0]  frame_length;

  modport source (output valid, cmd, nonce, packet_id, send_status, frame_length,
                  input ready);
  modport sink   (input valid, cmd, nonce, packet_id, send_status, frame_length,
                  output ready);
endinterface

interface arq_sdf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] out_nonce;
  logic [7:0]  out_packet_id;
  logic [1:0]  outcome;
  logic [7:0]  payload_length;
  logic        drop_reason;
  logic        last;

  modport source (output valid, kind, out_nonce, out_packet_id, outcome,
                  payload_length, drop_reason, last, input ready);
  modport sink   (input valid, kind, out_nonce, out_packet_id, outcome,
                  payload_length, drop_reason, last, output ready);
endinterface

`default_nettype wire

### design/arq_sdf_front.sv
// ----------------------------------------------------------------------------
// ARQ sender front end
// Accepts input beats and classifies them into operation records.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_sdf_front (
  arq_sdf_in_if.sink         in_i,
  output logic               op_valid_o,
  output arq_sdf_pkg::op_t   op_o,
  input  logic               op_ready_i
);
  import arq_sdf_pkg::*;

  // Handshake follows the queue space
  assign in_i.ready = op_ready_i;
  assign op_valid_o = in_i.valid;

  // Classification: status check, header length check, payload size
  always_comb begin
    op_o.cmd            = cmd_e'(in_i.cmd);
    op_o.nonce          = in_i.nonce;
    op_o.packet_id      = in_i.packet_id;
    op_o.status_ok      = (in_i.send_status == 8'd0);
    op_o.too_short      = (in_i.frame_length < HDR_LEN);
    op_o.payload_length = in_i.frame_length - HDR_LEN;
  end

endmodule

`default_nettype wire

### design/arq_sdf_opq.sv
// ----------------------------------------------------------------------------
// ARQ sender operation queue
// Short FIFO that decouples the front end from the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_sdf_opq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  arq_sdf_pkg::op_t push_op_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output arq_sdf_pkg::op_t pop_op_o,
  input  logic             pop_ready_i
);
  import arq_sdf_pkg::*;

  op_t                 mem_q [OPQ_DEPTH];
  logic [OPQ_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OPQ_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OPQ_CW-1:0]   cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != OPQ_CW'(OPQ_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill updates
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + OPQ_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + OPQ_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OPQ_CW'(push) - OPQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

### design/arq_sdf_back.sv
// ----------------------------------------------------------------------------
// ARQ sender back end
// Runs the stop-and-wait sender and the receive duplicate filter, and
// buffers up to two result beats per operation in a small result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_sdf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arq_sdf_pkg::cfg_t cfg_i,
  input  logic             op_valid_i,
  input  arq_sdf_pkg::op_t op_i,
  output logic             op_ready_o,
  arq_sdf_out_if.source    out_o
);
  import arq_sdf_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WAIT    = 2'd1;
  localparam logic [1:0] PH_BACKOFF = 2'd2;

  // Sender and filter state
  logic [1:0]  phase_q, phase_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [7:0]  retry_q, retry_d;
  logic [15:0] backoff_q, backoff_d;
  logic [31:0] tx_nonce_q, tx_nonce_d;
  logic [7:0]  tx_pid_q, tx_pid_d;
  logic [31:0] last_rx_q, last_rx_d;

  // Result queue
  res_t                res_mem_q [RESQ_DEPTH];
  logic [RESQ_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [RESQ_CW-1:0]  cnt_q;

  logic        op_fire, out_pop;
  logic [1:0]  n_res;
  res_t        res0, res1, res0_f, res1_f;
  logic [31:0] elapsed_inc;
  logic [7:0]  retry_inc;
  logic [15:0] backoff_dec;

  // Room for two beats before an operation is taken
  assign op_ready_o = (cnt_q <= RESQ_CW'(RESQ_DEPTH - 2));
  assign op_fire    = op_valid_i && op_ready_o;

  // Saturating counter steps
  assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 32'd1 : elapsed_q;
  assign retry_inc   = (retry_q != '1) ? retry_q + 8'd1 : retry_q;
  assign backoff_dec = (backoff_q != '0) ? backoff_q - 16'd1 : backoff_q;

  // Operation execution
  always_comb begin
    phase_d    = phase_q;
    elapsed_d  = elapsed_q;
    retry_d    = retry_q;
    backoff_d  = backoff_q;
    tx_nonce_d = tx_nonce_q;
    tx_pid_d   = tx_pid_q;
    last_rx_d  = last_rx_q;
    n_res      = 2'd0;
    res0       = '0;
    res1       = '0;
    if (op_fire) begin
      unique case (op_i.cmd)
        CMD_START: begin
          if (phase_q != PH_IDLE) begin
            res0  = make_res(KIND_BUSY, 32'd0, 8'd0, OUT_OK, 8'd0, DROP_SHORT);
            n_res = 2'd1;
          end else begin
            tx_nonce_d = op_i.nonce;
            tx_pid_d   = op_i.packet_id;
            elapsed_d  = '0;
            retry_d    = '0;
            backoff_d  = '0;
            phase_d    = PH_WAIT;
            res0  = make_res(KIND_TX_REQ, op_i.nonce, op_i.packet_id, OUT_OK, 8'd0,
                             DROP_SHORT);
            n_res = 2'd1;
            if (cfg_i.retry_limit == 8'd0) begin
              phase_d = PH_IDLE;
              res1  = make_res(KIND_OUTCOME, 32'd0, 8'd0, OUT_RETRIES, 8'd0, DROP_SHORT);
              n_res = 2'd2;
            end
          end
        end
        CMD_TX_DONE: begin
          if (phase_q == PH_WAIT) begin
            if (op_i.status_ok) begin
              phase_d = PH_IDLE;
              res0  = make_res(KIND_OUTCOME, 32'd0, 8'd0, OUT_OK, 8'd0, DROP_SHORT);
              n_res = 2'd1;
            end else begin
              retry_d = retry_inc;
              if (retry_inc >= cfg_i.retry_limit) begin
                phase_d = PH_IDLE;
                res0  = make_res(KIND_OUTCOME, 32'd0, 8'd0, OUT_RETRIES, 8'd0,
                                 DROP_SHORT);
                n_res = 2'd1;
              end else if (cfg_i.retry_backoff_ms == 16'd0) begin
                res0  = make_res(KIND_TX_REQ, tx_nonce_q, tx_pid_q, OUT_OK, 8'd0,
                                 DROP_SHORT);
                n_res = 2'd1;
              end else begin
                backoff_d = cfg_i.retry_backoff_ms;
                phase_d   = PH_BACKOFF;
              end
            end
          end
        end
        CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc > cfg_i.send_timeout_ms) begin
              phase_d = PH_IDLE;
              res0  = make_res(KIND_OUTCOME, 32'd0, 8'd0, OUT_TIMEOUT, 8'd0, DROP_SHORT);
              n_res = 2'd1;
            end else if (phase_q == PH_BACKOFF) begin
              backoff_d = backoff_dec;
              if (backoff_dec == 16'd0) begin
                phase_d = PH_WAIT;
                res0  = make_res(KIND_TX_REQ, tx_nonce_q, tx_pid_q, OUT_OK, 8'd0,
                                 DROP_SHORT);
                n_res = 2'd1;
              end
            end
          end
        end
        CMD_RX_HDR: begin
          n_res = 2'd1;
          if (op_i.too_short) begin
            res0 = make_res(KIND_RX_DROP, 32'd0, 8'd0, OUT_OK, 8'd0, DROP_SHORT);
          end else if (op_i.nonce == last_rx_q) begin
            res0 = make_res(KIND_RX_DROP, 32'd0, 8'd0, OUT_OK, 8'd0, DROP_DUP);
          end else begin
            last_rx_d = op_i.nonce;
            res0 = make_res(KIND_RX_DELIVER, op_i.nonce, op_i.packet_id, OUT_OK,
                            op_i.payload_length, DROP_SHORT);
          end
        end
        default: ;
      endcase
    end
  end

  // Mark the final beat of the operation
  always_comb begin
    res0_f      = res0;
    res1_f      = res1;
    res0_f.last = (n_res == 2'd1);
    res1_f.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      elapsed_q  <= '0;
      retry_q    <= '0;
      backoff_q  <= '0;
      tx_nonce_q <= '0;
      tx_pid_q   <= '0;
      last_rx_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      retry_q    <= retry_d;
      backoff_q  <= backoff_d;
      tx_nonce_q <= tx_nonce_d;
      tx_pid_q   <= tx_pid_d;
      last_rx_q  <= last_rx_d;
    end
  end

  // Result queue control
  assign out_pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RESQ_AW'(n_res);
      rd_ptr_q <= rd_ptr_q + RESQ_AW'(out_pop);
      cnt_q    <= cnt_q + RESQ_CW'(n_res) - RESQ_CW'(out_pop);
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      res_mem_q[wr_ptr_q] <= res0_f;
    end
    if (n_res == 2'd2) begin
      res_mem_q[wr_ptr_q + RESQ_AW'(1)] <= res1_f;
    end
  end

  // Output beat from the queue head
  always_comb begin
    out_o.valid          = (cnt_q != '0);
    out_o.kind           = res_mem_q[rd_ptr_q].kind;
    out_o.out_nonce      = res_mem_q[rd_ptr_q].out_nonce;
    out_o.out_packet_id  = res_mem_q[rd_ptr_q].out_packet_id;
    out_o.outcome        = res_mem_q[rd_ptr_q].outcome;
    out_o.payload_length = res_mem_q[rd_ptr_q].payload_length;
    out_o.drop_reason    = res_mem_q[rd_ptr_q].drop_reason;
    out_o.last           = res_mem_q[rd_ptr_q].last;
  end

endmodule

`default_nettype wire

### design/arq_sender_with_duplicate_filter_core.sv
// ----------------------------------------------------------------------------
// ARQ sender with duplicate filter
// Stop-and-wait retransmission controller plus receive duplicate filter.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one event per beat: start send, transmit done, millisecond
//   tick or received header. out_o returns result beats (transmit requests,
//   send outcomes, rx delivered/dropped, busy rejections); the last flag marks
//   the final beat caused by one input beat, which gives zero, one or two.
//   The cfg_* port writes retry_limit, retry_backoff_ms and send_timeout_ms;
//   the user must do so only while the block is idle, which it does not enforce.
// Flow:
//   An accepted input beat goes into the operation queue; the back end
//   executes it from the queue head and puts its result beats into the
//   result queue, whose head drives out_o. With out_o ready, one input beat
//   per cycle is sustained; the single output port paces two-beat items.
// Reset and stalls:
//   Reset returns the sender to idle, clears all counters and the last
//   accepted nonce, and restores the register defaults. When out_o stalls,
//   a four-beat result queue and a two-entry operation queue absorb items
//   until in_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arq_sender_with_duplicate_filter_core_macros.svh"

module arq_sender_with_duplicate_filter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  arq_sdf_in_if.sink    in_i,
  arq_sdf_out_if.source out_o
);
  import arq_sdf_pkg::*;

  cfg_t cfg_q;
  logic op_f_valid, op_f_ready;
  op_t  op_f;
  logic op_b_valid, op_b_ready;
  op_t  op_b;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit      <= 8'd3;
      cfg_q.retry_backoff_ms <= 16'd10;
      cfg_q.send_timeout_ms  <= 32'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RETRY_LIMIT:   cfg_q.retry_limit      <= cfg_wdata_i[7:0];
        REG_RETRY_BACKOFF: cfg_q.retry_backoff_ms <= cfg_wdata_i[15:0];
        REG_SEND_TIMEOUT:  cfg_q.send_timeout_ms  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front end: accept and classify
  arq_sdf_front u_front (
    .in_i       (in_i),
    .op_valid_o (op_f_valid),
    .op_o       (op_f),
    .op_ready_i (op_f_ready)
  );

  // Operation queue
  arq_sdf_opq u_opq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (op_f_valid),
    .push_op_i    (op_f),
    .push_ready_o (op_f_ready),
    .pop_valid_o  (op_b_valid),
    .pop_op_o     (op_b),
    .pop_ready_i  (op_b_ready)
  );

  // Back end: execute and emit results
  arq_sdf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (op_b_valid),
    .op_i       (op_b),
    .op_ready_o (op_b_ready),
    .out_o      (out_o)
  );

  // Checks
  `ARQ_ASSERT_NEXT(a_accept_queued, clk_i, rst_ni, in_i.valid && in_i.ready, op_b_valid, "accepted beat not queued")
  `ARQ_ASSERT_NOW(a_single_last, clk_i, rst_ni, out_o.valid && (out_o.kind == KIND_BUSY || out_o.kind == KIND_RX_DROP || out_o.kind == KIND_RX_DELIVER || out_o.kind == KIND_OUTCOME), out_o.last, "final-only beat without last")
  `ARQ_ASSERT_NOW(a_outcome_kind, clk_i, rst_ni, out_o.valid && out_o.kind != KIND_OUTCOME, out_o.outcome == OUT_OK, "outcome set on non-outcome beat")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARQ sender with duplicate filter testbench
// Drives event beats into the core under several register settings and
// checks each result beat against a cycle-free predictor of the sender and
// the receive filter, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb;
  import arq_sdf_pkg::*;

  localparam int unsigned LIMIT_CYCLES   = 400_000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned NUM_SETTINGS   = 6;
  localparam int unsigned ITEMS_PER_SET  = 300;

  // Register settings per phase: retry limit, back-off, timeout
  localparam logic [31:0] SET_LIMIT   [NUM_SETTINGS] = '{3, 0, 255, 1, 2, 200};
  localparam logic [31:0] SET_BACKOFF [NUM_SETTINGS] = '{10, 0, 0, 1, 65535, 3};
  localparam logic [31:0] SET_TIMEOUT [NUM_SETTINGS] =
    '{1000, 0, 5, 20, 30, 32'hFFFF_FFFF};
  // Idle percentages per phase: sender, receiver
  localparam int unsigned SET_TX_IDLE [NUM_SETTINGS] = '{35, 35, 52, 52, 0, 0};
  localparam int unsigned SET_RX_IDLE [NUM_SETTINGS] = '{52, 52, 35, 35, 0, 0};

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_BACKOFF = 2'd2
  } send_phase_e;

  // One input event beat
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] nonce;
    logic [7:0]  pid;
    logic [7:0]  status;
    logic [7:0]  flen;
  } arq_event_t;

  // --------------------------------------------------------------------------
  // Sender / filter predictor and result scoreboard
  // --------------------------------------------------------------------------
  class arq_predictor;
    logic [7:0]  retry_limit;
    logic [15:0] backoff_ms;
    logic [31:0] timeout_ms;

    send_phase_e ph;
    logic [31:0] elapsed;
    logic [7:0]  retries;
    logic [15:0] backoff_left;
    logic [31:0] tx_nonce;
    logic [7:0]  tx_pid;
    logic [31:0] last_rx;

    res_t        pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      retry_limit  = 8'd3;
      backoff_ms   = 16'd10;
      timeout_ms   = 32'd1000;
      ph           = PH_IDLE;
      elapsed      = '0;
      retries      = '0;
      backoff_left = '0;
      tx_nonce     = '0;
      tx_pid       = '0;
      last_rx      = '0;
      errors       = 0;
      checked      = 0;
    endfunction

    function res_t build(kind_e k, logic [31:0] n, logic [7:0] p, outcome_e oc,
                         logic [7:0] plen, logic drop);
      res_t r;
      r.kind           = k;
      r.out_nonce      = n;
      r.out_packet_id  = p;
      r.outcome        = oc;
      r.payload_length = plen;
      r.drop_reason    = drop;
      r.last           = 1'b0;
      return r;
    endfunction

    // Advance the model by one accepted beat and queue the results it causes
    function void take_event(arq_event_t ev);
      res_t beats[$];
      case (ev.cmd)
        CMD_START: begin
          if (ph != PH_IDLE) begin
            beats.push_back(build(KIND_BUSY, '0, '0, OUT_OK, '0, 1'b0));
          end else begin
            tx_nonce     = ev.nonce;
            tx_pid       = ev.pid;
            elapsed      = '0;
            retries      = '0;
            backoff_left = '0;
            ph           = PH_WAIT;
            beats.push_back(build(KIND_TX_REQ, tx_nonce, tx_pid, OUT_OK, '0, 1'b0));
            if (retry_limit == 0) begin
              ph = PH_IDLE;
              beats.push_back(build(KIND_OUTCOME, '0, '0, OUT_RETRIES, '0, 1'b0));
            end
          end
        end
        CMD_TX_DONE: begin
          // stray completions outside the wait phase are ignored
          if (ph == PH_WAIT) begin
            if (ev.status == 0) begin
              ph = PH_IDLE;
              beats.push_back(build(KIND_OUTCOME, '0, '0, OUT_OK, '0, 1'b0));
            end else begin
              if (retries != 8'hFF) retries++;
              if (retries >= retry_limit) begin
                ph = PH_IDLE;
                beats.push_back(build(KIND_OUTCOME, '0, '0, OUT_RETRIES, '0, 1'b0));
              end else if (backoff_ms == 0) begin
                beats.push_back(build(KIND_TX_REQ, tx_nonce, tx_pid, OUT_OK, '0, 1'b0));
              end else begin
                backoff_left = backoff_ms;
                ph           = PH_BACKOFF;
              end
            end
          end
        end
        CMD_TICK: begin
          // timeout wins over the back-off countdown
          if (ph != PH_IDLE) begin
            if (elapsed != 32'hFFFF_FFFF) elapsed++;
            if (elapsed > timeout_ms) begin
              ph = PH_IDLE;
              beats.push_back(build(KIND_OUTCOME, '0, '0, OUT_TIMEOUT, '0, 1'b0));
            end else if (ph == PH_BACKOFF) begin
              if (backoff_left != 0) backoff_left--;
              if (backoff_left == 0) begin
                ph = PH_WAIT;
                beats.push_back(build(KIND_TX_REQ, tx_nonce, tx_pid, OUT_OK, '0, 1'b0));
              end
            end
          end
        end
        default: begin
          if (ev.flen < HDR_LEN) begin
            beats.push_back(build(KIND_RX_DROP, '0, '0, OUT_OK, '0, DROP_SHORT));
          end else if (ev.nonce == last_rx) begin
            beats.push_back(build(KIND_RX_DROP, '0, '0, OUT_OK, '0, DROP_DUP));
          end else begin
            last_rx = ev.nonce;
            beats.push_back(build(KIND_RX_DELIVER, ev.nonce, ev.pid, OUT_OK,
                                  ev.flen - HDR_LEN, 1'b0));
          end
        end
      endcase
      if (beats.size() > 0) beats[beats.size() - 1].last = 1'b1;
      foreach (beats[i]) pending.push_back(beats[i]);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    // Compare one result beat with the oldest expectation
    task match_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %0d kind %0d arrived with nothing pending",
                         checked, got.kind));
      end else begin
        want = pending.pop_front();
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("out_nonce", got.out_nonce, want.out_nonce);
        check_field("out_packet_id", 32'(got.out_packet_id), 32'(want.out_packet_id));
        check_field("outcome", 32'(got.outcome), 32'(want.outcome));
        check_field("payload_length", 32'(got.payload_length), 32'(want.payload_length));
        check_field("drop_reason", 32'(got.drop_reason), 32'(want.drop_reason));
        check_field("last", 32'(got.last), 32'(want.last));
      end
      checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the core
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  arq_sdf_in_if  in_if ();
  arq_sdf_out_if out_if ();

  arq_predictor pred;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  int unsigned  hold_reqs;
  int unsigned  hold_done;
  int unsigned  hold_left;
  int unsigned  cycles;

  arq_sender_with_duplicate_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL arq_sender_with_duplicate_filter_core");
      $finish;
    end
  end

  // Receiver: random back-pressure plus long holds on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      out_if.ready <= 1'b0;
      hold_done    <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    res_t r;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      r.kind           = kind_e'(out_if.kind);
      r.out_nonce      = out_if.out_nonce;
      r.out_packet_id  = out_if.out_packet_id;
      r.outcome        = outcome_e'(out_if.outcome);
      r.payload_length = out_if.payload_length;
      r.drop_reason    = out_if.drop_reason;
      r.last           = out_if.last;
      pred.match_result(r);
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  function automatic arq_event_t mk(cmd_e c, logic [31:0] n, logic [7:0] p,
                                    logic [7:0] s, logic [7:0] f);
    arq_event_t ev;
    ev.cmd    = c;
    ev.nonce  = n;
    ev.pid    = p;
    ev.status = s;
    ev.flen   = f;
    return ev;
  endfunction

  // Offer one beat, with random gaps, and note it once accepted
  task automatic send_beat(input arq_event_t ev);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= ev.cmd;
    in_if.nonce        <= ev.nonce;
    in_if.packet_id    <= ev.pid;
    in_if.send_status  <= ev.status;
    in_if.frame_length <= ev.flen;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    pred.take_event(ev);
  endtask

  // Stop offering and let every pending result drain
  task automatic wait_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pred.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Bring an open send to an end so the registers can change
  task automatic close_send();
    while (pred.ph != PH_IDLE) begin
      if (pred.ph == PH_WAIT) send_beat(mk(CMD_TX_DONE, $urandom, 8'h00, 8'h00, 8'h00));
      else send_beat(mk(CMD_TICK, $urandom, 8'h00, 8'h00, 8'h00));
    end
    wait_results();
  endtask

  task automatic write_cfg(input logic [31:0] lim, input logic [31:0] bo,
                           input logic [31:0] tmo);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_RETRY_LIMIT;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    pred.retry_limit = lim[7:0];
    cfg_idx_i   <= REG_RETRY_BACKOFF;
    cfg_wdata_i <= bo;
    @(posedge clk_i);
    pred.backoff_ms = bo[15:0];
    cfg_idx_i   <= REG_SEND_TIMEOUT;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    pred.timeout_ms = tmo;
    cfg_we_i    <= 1'b0;
  endtask

  // Random beat, shaped by where the send currently is
  function automatic arq_event_t random_event();
    arq_event_t  ev;
    int unsigned roll;
    ev    = mk(CMD_TICK, $urandom, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(250)));
    roll  = $urandom_range(99);
    case (pred.ph)
      PH_IDLE: ev.cmd = roll < 40 ? CMD_START : roll < 75 ? CMD_RX_HDR :
                        roll < 90 ? CMD_TICK : CMD_TX_DONE;
      PH_WAIT: ev.cmd = roll < 40 ? CMD_TX_DONE : roll < 70 ? CMD_TICK :
                        roll < 80 ? CMD_START : CMD_RX_HDR;
      default: ev.cmd = roll < 60 ? CMD_TICK : roll < 70 ? CMD_TX_DONE :
                        roll < 80 ? CMD_START : CMD_RX_HDR;
    endcase
    // about half the completions succeed
    if (ev.cmd == CMD_TX_DONE && $urandom_range(1) == 0) ev.status = 8'h00;
    if (ev.cmd == CMD_RX_HDR) begin
      roll = $urandom_range(99);
      if (roll < 25) ev.nonce = pred.last_rx;
      else if (roll < 30) ev.nonce = '0;
      roll = $urandom_range(99);
      if (roll < 15) ev.flen = 8'($urandom_range(HDR_LEN - 1));
      else if (roll < 20) ev.flen = 8'd250;
      else ev.flen = 8'($urandom_range(250, HDR_LEN));
    end
    return ev;
  endfunction

  // Short directed sequence on the reset settings
  task automatic run_directed();
    // zero nonce matches the reset value of the last accepted nonce
    send_beat(mk(CMD_RX_HDR, 32'h0, 8'h11, 8'h00, HDR_LEN));
    send_beat(mk(CMD_RX_HDR, 32'h1234_5678, 8'h00, 8'h00, HDR_LEN - 8'd1));
    send_beat(mk(CMD_RX_HDR, 32'h1234_5678, 8'h00, 8'h00, 8'd0));
    send_beat(mk(CMD_RX_HDR, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'd250));
    send_beat(mk(CMD_RX_HDR, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'd100));
    send_beat(mk(CMD_RX_HDR, 32'h0000_0001, 8'h80, 8'h00, HDR_LEN));
    // ticks and completions while idle do nothing
    send_beat(mk(CMD_TICK, 32'h0, 8'h00, 8'h00, 8'h00));
    send_beat(mk(CMD_TX_DONE, 32'h0, 8'h00, 8'h01, 8'h00));
    send_beat(mk(CMD_START, 32'hA5A5_5A5A, 8'h7E, 8'h00, 8'h00));
    send_beat(mk(CMD_START, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFA));
    send_beat(mk(CMD_TX_DONE, 32'h0, 8'h00, 8'hFF, 8'h00));
    // completion during back-off is stray
    send_beat(mk(CMD_TX_DONE, 32'h0, 8'h00, 8'h00, 8'h00));
    send_beat(mk(CMD_RX_HDR, 32'h0000_0002, 8'h01, 8'h00, 8'd9));
    repeat (10) send_beat(mk(CMD_TICK, 32'h0, 8'h00, 8'h00, 8'h00));
    send_beat(mk(CMD_TX_DONE, 32'h0, 8'h00, 8'h00, 8'h00));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    pred                = new();
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_RETRY_LIMIT;
    cfg_wdata_i         = '0;
    in_if.valid         = 1'b0;
    in_if.cmd           = CMD_START;
    in_if.nonce         = '0;
    in_if.packet_id     = '0;
    in_if.send_status   = '0;
    in_if.frame_length  = '0;
    out_if.ready        = 1'b0;
    tx_idle_pct         = 0;
    rx_idle_pct         = 0;
    hold_reqs           = 0;
    hold_done           = 0;
    hold_left           = 0;
    cycles              = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    close_send();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      write_cfg(SET_LIMIT[p], SET_BACKOFF[p], SET_TIMEOUT[p]);
      tx_idle_pct <= SET_TX_IDLE[p];
      rx_idle_pct <= SET_RX_IDLE[p];
      // long receiver hold so the core fills up and stalls its input
      if (p == 0 || p == 4) hold_reqs <= hold_reqs + 1;
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if (i == ITEMS_PER_SET / 2) wait_results();
        send_beat(random_event());
      end
      close_send();
    end

    if (pred.errors == 0) begin
      $display("PASS arq_sender_with_duplicate_filter_core");
    end else begin
      $display("FAIL arq_sender_with_duplicate_filter_core");
    end
    $finish;
  end

endmodule
